// ----- hdl/cube_map_texel_address_assert.svh -----
// ----------------------------------------------------------------------------
// Cube map texel address assertion macros
// Checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_TEXEL_ADDRESS_ASSERT_SVH
`define CUBE_MAP_TEXEL_ADDRESS_ASSERT_SVH

// ante implies cons in the same cycle
`define CMTA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond never holds
`define CMTA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hdl/cmta_pkg.sv -----
// ----------------------------------------------------------------------------
// cmta_pkg
// Shared types and constants of the cube map texel address pipeline.
// ----------------------------------------------------------------------------
package cmta_pkg;

	// configuration register widths
	localparam int CFG_SIZE_W    = 13;
	localparam int CFG_PRESENT_W = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;

	// texel item field widths
	localparam int TEXEL_W = 12;
	localparam int INDEX_W = 24;

	// face coordinate: 16 fraction bits, value 0..65536
	localparam int FRAC_BITS  = 16;
	localparam int COORD_W    = FRAC_BITS + 1;
	localparam logic [COORD_W-1:0] COORD_HALF = 17'd32768;

	// divider: two quotient bits per stage
	localparam int DIV_STAGES = 8;
	localparam int DIV_STEPS  = FRAC_BITS / DIV_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FACE_WIDTH   = 2'd0,
		CFG_FACE_HEIGHT  = 2'd1,
		CFG_FACE_PRESENT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FACE_NEG_Z = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_X = 3'd2,
		FACE_POS_Z = 3'd3,
		FACE_POS_Y = 3'd4,
		FACE_NEG_Y = 3'd5
	} face_t;

	// per-item control that rides along the divider
	typedef struct packed {
		face_t face;
		logic  minus_u;
		logic  minus_v;
		logic  zero;
	} side_t;

endpackage

// ----- hdl/cmta_if.sv -----
// ----------------------------------------------------------------------------
// cmta_if
// Valid/ready channels: direction items in, texel items out, config writes.
// ----------------------------------------------------------------------------
interface cmta_dir_if #(
	parameter int DIR_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [DIR_BITS-1:0] dir_x;
	logic signed [DIR_BITS-1:0] dir_y;
	logic signed [DIR_BITS-1:0] dir_z;

	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmta_texel_if #(
	parameter int TX_W  = 12,
	parameter int IDX_W = 24
);
	logic             valid;
	logic             ready;
	logic [2:0]       face;
	logic [TX_W-1:0]  texel_x;
	logic [TX_W-1:0]  texel_y;
	logic [IDX_W-1:0] texel_index;
	logic             hit;

	modport source (output valid, face, texel_x, texel_y, texel_index, hit, input ready);
	modport sink   (input valid, face, texel_x, texel_y, texel_index, hit, output ready);
endinterface

interface cmta_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cmta_pkg::CFG_IDX_W-1:0]  index;
	logic [cmta_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/cmta_face_sel.sv -----
// ----------------------------------------------------------------------------
// cmta_face_sel
// Stage 1: component magnitudes, major axis, face and minor operands.
// ----------------------------------------------------------------------------
module cmta_face_sel #(
	parameter int DIR_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic signed [DIR_BITS-1:0] dir_x,
	input  logic signed [DIR_BITS-1:0] dir_y,
	input  logic signed [DIR_BITS-1:0] dir_z,
	output logic                       valid_s1,
	output cmta_pkg::side_t            side_s1,
	output logic [DIR_BITS-1:0]        a_u_s1,
	output logic [DIR_BITS-1:0]        a_v_s1,
	output logic [DIR_BITS-1:0]        m_s1
);
	logic [DIR_BITS-1:0] ax, ay, az, m, a_u, a_v;
	logic                x_maj, y_maj, x_pos, y_pos, z_pos;
	logic                sx, sy, sz;
	cmta_pkg::side_t     side;

	// two's complement magnitude; the most negative code reads as 2^(DIR_BITS-1)
	assign ax = dir_x[DIR_BITS-1] ? (~dir_x + 1'b1) : dir_x;
	assign ay = dir_y[DIR_BITS-1] ? (~dir_y + 1'b1) : dir_y;
	assign az = dir_z[DIR_BITS-1] ? (~dir_z + 1'b1) : dir_z;

	assign sx = dir_x[DIR_BITS-1];
	assign sy = dir_y[DIR_BITS-1];
	assign sz = dir_z[DIR_BITS-1];
	assign x_pos = !sx && (dir_x != '0);
	assign y_pos = !sy && (dir_y != '0);
	assign z_pos = !sz && (dir_z != '0);

	// ties go to x, then y
	assign x_maj = (ax >= ay) && (ax >= az);
	assign y_maj = !x_maj && (ay >= az);

	always_comb begin
		side = '0;
		if (x_maj) begin
			m            = ax;
			side.face    = x_pos ? cmta_pkg::FACE_POS_X : cmta_pkg::FACE_NEG_X;
			a_u          = az;
			side.minus_u = sz != !x_pos;
			a_v          = ay;
			side.minus_v = sy;
		end else if (y_maj) begin
			m            = ay;
			side.face    = y_pos ? cmta_pkg::FACE_POS_Y : cmta_pkg::FACE_NEG_Y;
			a_u          = ax;
			side.minus_u = sx;
			a_v          = az;
			side.minus_v = sz != !y_pos;
		end else begin
			m            = az;
			side.face    = z_pos ? cmta_pkg::FACE_POS_Z : cmta_pkg::FACE_NEG_Z;
			a_u          = ax;
			side.minus_u = sx != z_pos;
			a_v          = ay;
			side.minus_v = sy;
		end
		side.zero = (m == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side;
			a_u_s1  <= a_u;
			a_v_s1  <= a_v;
			m_s1    <= m;
		end
	end

endmodule

// ----- hdl/cmta_div.sv -----
// ----------------------------------------------------------------------------
// cmta_div
// Pipelined restoring divider, two lanes sharing one divisor:
// q = floor(a * 2^15 / m) for a <= m, two quotient bits per stage.
// ----------------------------------------------------------------------------
module cmta_div #(
	parameter int DIR_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  cmta_pkg::side_t                   in_side,
	input  logic [DIR_BITS-1:0]               in_a_u,
	input  logic [DIR_BITS-1:0]               in_a_v,
	input  logic [DIR_BITS-1:0]               in_m,
	output logic                              out_valid,
	output cmta_pkg::side_t                   out_side,
	output logic [cmta_pkg::FRAC_BITS-1:0]    q_u,
	output logic [cmta_pkg::FRAC_BITS-1:0]    q_v
);
	localparam int RW = DIR_BITS + 1;
	localparam int NS = cmta_pkg::DIV_STAGES;
	localparam int QW = cmta_pkg::FRAC_BITS;

	logic            valid_s [NS];
	cmta_pkg::side_t side_s  [NS];
	logic [RW-1:0]   m_s     [NS];
	logic [RW-1:0]   r_u_s   [NS];
	logic [RW-1:0]   r_v_s   [NS];
	logic [QW-1:0]   q_u_s   [NS];
	logic [QW-1:0]   q_v_s   [NS];

	// one compare-subtract; shift first unless it is the leading bit
	function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
		input logic [RW-1:0] m, input logic shift);
		logic [RW-1:0] t;
		t = shift ? {r[RW-2:0], 1'b0} : r;
		if (t >= m) begin
			div_step = {1'b1, t - m};
		end else begin
			div_step = {1'b0, t};
		end
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic            src_valid;
		cmta_pkg::side_t src_side;
		logic [RW-1:0]   src_m, src_r_u, src_r_v, nxt_r_u, nxt_r_v;
		logic [QW-1:0]   src_q_u, src_q_v, nxt_q_u, nxt_q_v;
		logic [RW:0]     st_u, st_v;

		if (k == 0) begin : g_first
			assign src_valid = in_valid;
			assign src_side  = in_side;
			assign src_m     = {1'b0, in_m};
			assign src_r_u   = {1'b0, in_a_u};
			assign src_r_v   = {1'b0, in_a_v};
			assign src_q_u   = '0;
			assign src_q_v   = '0;
		end else begin : g_next
			assign src_valid = valid_s[k-1];
			assign src_side  = side_s[k-1];
			assign src_m     = m_s[k-1];
			assign src_r_u   = r_u_s[k-1];
			assign src_r_v   = r_v_s[k-1];
			assign src_q_u   = q_u_s[k-1];
			assign src_q_v   = q_v_s[k-1];
		end

		always_comb begin
			nxt_r_u = src_r_u;
			nxt_r_v = src_r_v;
			nxt_q_u = src_q_u;
			nxt_q_v = src_q_v;
			st_u    = '0;
			st_v    = '0;
			for (int i = 0; i < cmta_pkg::DIV_STEPS; i++) begin
				st_u    = div_step(nxt_r_u, src_m, !(k == 0 && i == 0));
				st_v    = div_step(nxt_r_v, src_m, !(k == 0 && i == 0));
				nxt_r_u = st_u[RW-1:0];
				nxt_r_v = st_v[RW-1:0];
				nxt_q_u = {nxt_q_u[QW-2:0], st_u[RW]};
				nxt_q_v = {nxt_q_v[QW-2:0], st_v[RW]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= src_side;
				m_s[k]    <= src_m;
				r_u_s[k]  <= nxt_r_u;
				r_v_s[k]  <= nxt_r_v;
				q_u_s[k]  <= nxt_q_u;
				q_v_s[k]  <= nxt_q_v;
			end
		end
	end

	assign out_valid = valid_s[NS-1];
	assign out_side  = side_s[NS-1];
	assign q_u       = q_u_s[NS-1];
	assign q_v       = q_v_s[NS-1];

endmodule

// ----- hdl/cmta_scale.sv -----
// ----------------------------------------------------------------------------
// cmta_scale
// Face coordinates, texel scaling and clamp, linear index, output register.
// ----------------------------------------------------------------------------
module cmta_scale #(
	parameter int TX_W  = 12,
	parameter int IDX_W = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_valid,
	input  cmta_pkg::side_t                      in_side,
	input  logic [cmta_pkg::FRAC_BITS-1:0]       q_u,
	input  logic [cmta_pkg::FRAC_BITS-1:0]       q_v,
	input  logic [cmta_pkg::CFG_SIZE_W-1:0]      width,
	input  logic [cmta_pkg::CFG_SIZE_W-1:0]      height,
	input  logic [cmta_pkg::CFG_PRESENT_W-1:0]   present,
	output logic                                 out_valid,
	output logic [2:0]                           face,
	output logic [TX_W-1:0]                      texel_x,
	output logic [TX_W-1:0]                      texel_y,
	output logic [IDX_W-1:0]                     texel_index,
	output logic                                 hit
);
	localparam int SZ_W = cmta_pkg::CFG_SIZE_W;
	localparam int CW   = cmta_pkg::COORD_W;
	localparam int PW   = CW + SZ_W;
	localparam int TW   = PW - cmta_pkg::FRAC_BITS;
	localparam int IY_W = 2 * SZ_W;

	// stage 10: coordinates and hit
	logic                  valid_s10, hit_s10;
	cmta_pkg::face_t       face_s10;
	logic [CW-1:0]         u_s10, v_s10;
	// stage 11: scaled
	logic                  valid_s11, hit_s11;
	cmta_pkg::face_t       face_s11;
	logic [TW-1:0]         tu_s11, tv_s11;
	// stage 12: clamped, full size width until the output register
	logic                  valid_s12, hit_s12;
	cmta_pkg::face_t       face_s12;
	logic [SZ_W-1:0]       tx_s12, ty_s12;
	// stage 13: row offset
	logic                  valid_s13, hit_s13;
	cmta_pkg::face_t       face_s13;
	logic [SZ_W-1:0]       tx_s13, ty_s13;
	logic [IY_W-1:0]       iy_s13;

	logic [PW-1:0]         pu, pv;
	logic [IY_W-1:0]       idx_sum;
	logic                  hit_nxt;
	logic                  face_on;

	assign face_on = present[in_side.face];
	assign hit_nxt = !in_side.zero && face_on && (width != '0) && (height != '0);
	assign pu      = PW'(u_s10) * PW'(width);
	assign pv      = PW'(v_s10) * PW'(height);
	assign idx_sum = iy_s13 + IY_W'(tx_s13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s10 <= in_valid;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			out_valid <= valid_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s10  <= hit_nxt;
			face_s10 <= in_side.zero ? cmta_pkg::FACE_NEG_Z : in_side.face;
			u_s10    <= in_side.minus_u ? cmta_pkg::COORD_HALF - CW'(q_u)
				: cmta_pkg::COORD_HALF + CW'(q_u);
			v_s10    <= in_side.minus_v ? cmta_pkg::COORD_HALF - CW'(q_v)
				: cmta_pkg::COORD_HALF + CW'(q_v);

			hit_s11  <= hit_s10;
			face_s11 <= face_s10;
			tu_s11   <= pu[PW-1:cmta_pkg::FRAC_BITS];
			tv_s11   <= pv[PW-1:cmta_pkg::FRAC_BITS];

			// full ratio lands on the far edge: clamp to size minus one
			hit_s12  <= hit_s11;
			face_s12 <= face_s11;
			tx_s12   <= (tu_s11 >= TW'(width)) ? width - 1'b1 : SZ_W'(tu_s11);
			ty_s12   <= (tv_s11 >= TW'(height)) ? height - 1'b1 : SZ_W'(tv_s11);

			hit_s13  <= hit_s12;
			face_s13 <= face_s12;
			tx_s13   <= tx_s12;
			ty_s13   <= ty_s12;
			iy_s13   <= IY_W'(ty_s12) * IY_W'(width);

			hit         <= hit_s13;
			face        <= face_s13;
			texel_x     <= hit_s13 ? TX_W'(tx_s13) : '0;
			texel_y     <= hit_s13 ? TX_W'(ty_s13) : '0;
			texel_index <= hit_s13 ? IDX_W'(idx_sum) : '0;
		end
	end

endmodule

// ----- hdl/cube_map_texel_address.sv -----
// ----------------------------------------------------------------------------
// cube_map_texel_address - direction vector to cube face texel address
// The pipeline has 14 register stages (1 select, 8 divide, 5 scale).
// Throughput: one item per cycle while the output is not stalled; the divider retires 2 quotient bits per stage.
// Reset: arst_n clears all valid bits; face size 256 x 256, all six faces present.
// ----------------------------------------------------------------------------
module cube_map_texel_address #(
	parameter int MAX_FACE_SIZE = 4096,
	parameter int DIR_BITS      = 16
) (
	input logic          clk,
	input logic          arst_n,
	cmta_dir_if.sink     dir,
	cmta_texel_if.source texel,
	cmta_cfg_if.sink     cfg
);
	`include "cube_map_texel_address_assert.svh"

	localparam int SZ_W = cmta_pkg::CFG_SIZE_W;
	localparam int PR_W = cmta_pkg::CFG_PRESENT_W;
	localparam int TX_W = cmta_pkg::TEXEL_W;
	localparam int IDX_W = cmta_pkg::INDEX_W;
	localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_FACE_SIZE);

	// configuration registers
	logic [SZ_W-1:0] face_width_q, face_height_q;
	logic [PR_W-1:0] face_present_q;
	logic [SZ_W-1:0] width_sat, height_sat;

	// whole pipeline moves together; the output register frees as it drains
	logic adv;

	// stage 1 -> divider
	logic                  valid_s1;
	cmta_pkg::side_t       side_s1;
	logic [DIR_BITS-1:0]   a_u_s1, a_v_s1, m_s1;

	// divider -> scale
	logic                             div_valid;
	cmta_pkg::side_t                  div_side;
	logic [cmta_pkg::FRAC_BITS-1:0]   div_q_u, div_q_v;

	assign adv       = !texel.valid || texel.ready;
	assign dir.ready = adv;
	assign cfg.ready = 1'b1;

	// sizes above the supported maximum saturate
	assign width_sat  = (32'(face_width_q) > MAX_FACE_SIZE) ? MAX_SZ : face_width_q;
	assign height_sat = (32'(face_height_q) > MAX_FACE_SIZE) ? MAX_SZ : face_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q   <= 13'd256;
			face_height_q  <= 13'd256;
			face_present_q <= 6'h3f;
		end else if (cfg.valid && cfg.ready) begin
			case (cmta_pkg::cfg_reg_t'(cfg.index))
				cmta_pkg::CFG_FACE_WIDTH: begin
					face_width_q <= cfg.data;
				end
				cmta_pkg::CFG_FACE_HEIGHT: begin
					face_height_q <= cfg.data;
				end
				cmta_pkg::CFG_FACE_PRESENT: begin
					face_present_q <= cfg.data[PR_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	cmta_face_sel #(
		.DIR_BITS (DIR_BITS)
	) u_face_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (dir.valid),
		.dir_x    (dir.dir_x),
		.dir_y    (dir.dir_y),
		.dir_z    (dir.dir_z),
		.valid_s1 (valid_s1),
		.side_s1  (side_s1),
		.a_u_s1   (a_u_s1),
		.a_v_s1   (a_v_s1),
		.m_s1     (m_s1)
	);

	cmta_div #(
		.DIR_BITS (DIR_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s1),
		.in_side   (side_s1),
		.in_a_u    (a_u_s1),
		.in_a_v    (a_v_s1),
		.in_m      (m_s1),
		.out_valid (div_valid),
		.out_side  (div_side),
		.q_u       (div_q_u),
		.q_v       (div_q_v)
	);

	cmta_scale #(
		.TX_W  (TX_W),
		.IDX_W (IDX_W)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (div_valid),
		.in_side     (div_side),
		.q_u         (div_q_u),
		.q_v         (div_q_v),
		.width       (width_sat),
		.height      (height_sat),
		.present     (face_present_q),
		.out_valid   (texel.valid),
		.face        (texel.face),
		.texel_x     (texel.texel_x),
		.texel_y     (texel.texel_y),
		.texel_index (texel.texel_index),
		.hit         (texel.hit)
	);

	// ---- checks ----
	`CMTA_ASSERT_NEVER(a_face_range, texel.valid && (texel.face > 3'd5), "face code out of range")
	`CMTA_ASSERT_IMPL(a_hit_present, texel.valid && texel.hit && (texel.face <= 3'd5), face_present_q[texel.face], "hit on absent face")
	`CMTA_ASSERT_IMPL(a_hit_bounds, texel.valid && texel.hit, (texel.texel_x < face_width_q) && (texel.texel_y < face_height_q), "texel outside face")
	`CMTA_ASSERT_IMPL(a_miss_zero, texel.valid && !texel.hit, (texel.texel_x == '0) && (texel.texel_y == '0) && (texel.texel_index == '0), "miss with nonzero address")
	`CMTA_ASSERT_IMPL(a_stall_cause, !dir.ready, texel.valid && !texel.ready, "input held without output backpressure")

endmodule
